// ===== rtl/tdd_pkg.sv =====
// ============================================================================
// tdd_pkg : shared types and constants for the tilt direction detector
// Codes, field widths, the arctangent table and the sequencer states.
// ============================================================================
package tdd_pkg;

    localparam int AccelW    = 16;
    localparam int CfgW      = 10;
    localparam int CfgIdxW   = 2;
    localparam int AngleW    = 11;
    localparam int MoveW     = 3;
    localparam int IndW      = 4;
    localparam int CordicN   = 16;
    localparam int IterW     = 4;
    localparam int VecW      = 27;   // CORDIC x/y, vector length stays below 2^25
    localparam int AngAccW   = 20;   // CORDIC angle sum, 1/256 of a tenth of a degree
    localparam int AtanW     = 17;

    localparam logic [CfgW-1:0] TriggerReset = 10'd200;
    localparam logic [CfgW-1:0] ReleaseReset = 10'd100;
    localparam logic [CfgW-1:0] TrendReset   = 10'd50;

    localparam logic signed [AngleW-1:0] AngleMax = 11'sd900;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TRIGGER = 2'd0,
        CFG_RELEASE = 2'd1,
        CFG_TREND   = 2'd2
    } cfg_idx_t;

    typedef enum logic [MoveW-1:0] {
        MOVE_LEFT  = 3'd0,
        MOVE_RIGHT = 3'd1,
        MOVE_UP    = 3'd2,
        MOVE_DOWN  = 3'd3,
        MOVE_NONE  = 3'd4
    } move_t;

    typedef enum logic [IndW-1:0] {
        IND_FLAT        = 4'd0,
        IND_UP          = 4'd1,
        IND_DOWN        = 4'd2,
        IND_LEFT        = 4'd3,
        IND_RIGHT       = 4'd4,
        IND_UP_TREND    = 4'd5,
        IND_DOWN_TREND  = 4'd6,
        IND_LEFT_TREND  = 4'd7,
        IND_RIGHT_TREND = 4'd8
    } ind_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQR  = 7'b0000010,
        ST_SUM  = 7'b0000100,
        ST_ROOT = 7'b0001000,
        ST_ROT  = 7'b0010000,
        ST_ANG  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    // atan(2^-i) in degrees times 2560, rounded
    function automatic logic [AtanW-1:0] atan_lut(input logic [IterW-1:0] i);
        logic [AtanW-1:0] v;
        case (i)
            4'd0:    v = 17'd115200;
            4'd1:    v = 17'd68007;
            4'd2:    v = 17'd35933;
            4'd3:    v = 17'd18240;
            4'd4:    v = 17'd9155;
            4'd5:    v = 17'd4582;
            4'd6:    v = 17'd2292;
            4'd7:    v = 17'd1146;
            4'd8:    v = 17'd573;
            4'd9:    v = 17'd286;
            4'd10:   v = 17'd143;
            4'd11:   v = 17'd72;
            4'd12:   v = 17'd36;
            4'd13:   v = 17'd18;
            4'd14:   v = 17'd9;
            4'd15:   v = 17'd4;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/tdd_in_if.sv =====
// ============================================================================
// tdd_in_if : sample request channel
// Valid/ready handshake carrying one three-axis acceleration sample.
// ============================================================================
interface tdd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [tdd_pkg::AccelW-1:0]   accel_x;
    logic signed [tdd_pkg::AccelW-1:0]   accel_y;
    logic signed [tdd_pkg::AccelW-1:0]   accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

// ===== rtl/tdd_out_if.sv =====
// ============================================================================
// tdd_out_if : result request channel
// Valid/ready handshake carrying move, indicator, both angles and the axis pick.
// ============================================================================
interface tdd_out_if;
    logic                                valid;
    logic                                ready;
    logic [tdd_pkg::MoveW-1:0]           move;
    logic [tdd_pkg::IndW-1:0]            indicator;
    logic signed [tdd_pkg::AngleW-1:0]   pitch_tenths;
    logic signed [tdd_pkg::AngleW-1:0]   roll_tenths;
    logic                                roll_dominant;

    modport source (output valid, output move, output indicator, output pitch_tenths,
                    output roll_tenths, output roll_dominant, input ready);
    modport sink   (input valid, input move, input indicator, input pitch_tenths,
                    input roll_tenths, input roll_dominant, output ready);
endinterface

// ===== rtl/tilt_direction_detector_unit.sv =====
// ============================================================================
// tilt_direction_detector_unit : pitch/roll tilt detector with move latch
// Squares, integer roots and CORDIC arctangents, one bit or step a cycle.
// ============================================================================
// Flow: each accepted sample is squared, summed, rooted, rotated by CORDIC,
//   turned into angles and decided before the result goes valid.
// The 16-step serial squarer, root and CORDIC units handle one sample at a
//   time, and the next request is taken only in the idle state; a new
//   sample waits until the last one is done. A stalled result holds the decide step.
// Reset: async active low; sequencer idle, result empty, detector armed,
//   thresholds back to 200 / 100 / 50 tenths.
module tilt_direction_detector_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    tdd_in_if.sink                       sample,
    tdd_out_if.source                    result,
    input  logic                         cfg_wen,
    input  logic [tdd_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [tdd_pkg::CfgW-1:0]     cfg_wdata
);

    localparam int SqW   = 2 * tdd_pkg::AccelW - 1;  // |a|^2 <= 2^30
    localparam int RadW  = 2 * tdd_pkg::AccelW;      // sum of two squares
    localparam int RootW = tdd_pkg::AccelW;
    localparam int RemW  = RootW + 2;
    localparam int AngW  = tdd_pkg::AngleW;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    tdd_pkg::state_t                 state_reg, state_next;
    logic [tdd_pkg::IterW-1:0]       cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            awaiting_reg, awaiting_next;
    logic [tdd_pkg::CfgW-1:0]        trig_reg, rel_reg, trend_reg;

    // ------------------------------------------------------------------
    // Datapath storage
    // Lane 0 of root/CORDIC is pitch (num = x), lane 1 is roll (num = y).
    // Squarer lanes: 0 = x, 1 = y, 2 = z.
    // ------------------------------------------------------------------
    logic signed [tdd_pkg::AccelW-1:0]  num_reg   [2];
    logic [SqW-1:0]                     mcand_reg [3];
    logic [tdd_pkg::AccelW-1:0]         mplier_reg[3];
    logic [SqW-1:0]                     sq_reg    [3];
    logic [RadW-1:0]                    rad_reg   [2];
    logic [RemW-1:0]                    rem_reg   [2];
    logic [RootW-1:0]                   root_reg  [2];
    logic signed [tdd_pkg::VecW-1:0]    cx_reg    [2];
    logic signed [tdd_pkg::VecW-1:0]    cy_reg    [2];
    logic signed [tdd_pkg::AngAccW-1:0] cz_reg    [2];
    logic                               zero_reg  [2];
    logic signed [AngW-1:0]             ang_reg   [2];

    logic [tdd_pkg::MoveW-1:0]          move_reg;
    logic [tdd_pkg::IndW-1:0]           ind_reg;
    logic signed [AngW-1:0]             pitch_out_reg, roll_out_reg;
    logic                               rdom_reg;

    logic accept;
    logic commit;
    logic last_step;

    assign accept    = sample.valid && sample.ready;
    assign commit    = (state_reg == tdd_pkg::ST_DONE) && (!out_valid_reg || result.ready);
    assign last_step = (cnt_reg == {tdd_pkg::IterW{1'b1}});

    assign sample.ready = (state_reg == tdd_pkg::ST_IDLE);

    function automatic logic [tdd_pkg::AccelW-1:0] mag16(
        input logic signed [tdd_pkg::AccelW-1:0] v);
        // -32768 maps to 32768, still fits unsigned
        return v[tdd_pkg::AccelW-1] ? tdd_pkg::AccelW'(-v) : tdd_pkg::AccelW'(v);
    endfunction

    // ------------------------------------------------------------------
    // Root step: one result bit per cycle, restoring method
    // ------------------------------------------------------------------
    logic [RemW+1:0]  rem_sh  [2];
    logic [RemW+1:0]  trial   [2];
    logic [RemW-1:0]  rem_nx  [2];
    logic [RootW-1:0] root_nx [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            rem_sh[l] = {rem_reg[l], rad_reg[l][RadW-1 -: 2]};
            trial[l]  = {2'b00, root_reg[l], 2'b01};
            if (rem_sh[l] >= trial[l])
            begin
                rem_nx[l]  = RemW'(rem_sh[l] - trial[l]);
                root_nx[l] = {root_reg[l][RootW-2:0], 1'b1};
            end
            else
            begin
                rem_nx[l]  = RemW'(rem_sh[l]);
                root_nx[l] = {root_reg[l][RootW-2:0], 1'b0};
            end
        end
    end

    // ------------------------------------------------------------------
    // CORDIC vectoring step: drive y toward zero, sum the rotation angle
    // ------------------------------------------------------------------
    logic signed [tdd_pkg::VecW-1:0]    xs       [2];
    logic signed [tdd_pkg::VecW-1:0]    ys       [2];
    logic signed [tdd_pkg::AngAccW-1:0] atan_s;

    assign atan_s = $signed({{(tdd_pkg::AngAccW - tdd_pkg::AtanW){1'b0}},
                             tdd_pkg::atan_lut(cnt_reg)});

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            xs[l] = cx_reg[l] >>> cnt_reg;
            ys[l] = cy_reg[l] >>> cnt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Angle: round the sum to tenths, clamp to +-90.0 degrees
    // ------------------------------------------------------------------
    logic signed [tdd_pkg::AngAccW-1:0] zr       [2];
    logic signed [tdd_pkg::AngAccW-9:0] tq       [2];
    logic signed [AngW-1:0]             ang_sat  [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            zr[l] = cz_reg[l] + tdd_pkg::AngAccW'(128);
            tq[l] = zr[l][tdd_pkg::AngAccW-1:8];
            if (zero_reg[l])
                ang_sat[l] = '0;
            else if (tq[l] > (tdd_pkg::AngAccW-8)'(tdd_pkg::AngleMax))
                ang_sat[l] = tdd_pkg::AngleMax;
            else if (tq[l] < -(tdd_pkg::AngAccW-8)'(tdd_pkg::AngleMax))
                ang_sat[l] = -tdd_pkg::AngleMax;
            else
                ang_sat[l] = AngW'(tq[l]);
        end
    end

    // ------------------------------------------------------------------
    // Decision: dominant axis, thresholds, release latch
    // ------------------------------------------------------------------
    logic signed [AngW:0]       p12, r12, trig12, trend12;
    logic [tdd_pkg::CfgW-1:0]   p_abs, r_abs;
    logic                       roll_dom;
    tdd_pkg::move_t             dir;
    tdd_pkg::ind_t              ind;
    tdd_pkg::move_t             move_val;
    logic                       blocked;
    logic                       rearm;

    always_comb
    begin
        p12     = {ang_reg[0][AngW-1], ang_reg[0]};
        r12     = {ang_reg[1][AngW-1], ang_reg[1]};
        trig12  = $signed({2'b00, trig_reg});
        trend12 = $signed({2'b00, trend_reg});
        p_abs   = tdd_pkg::CfgW'(ang_reg[0][AngW-1] ? -p12 : p12);
        r_abs   = tdd_pkg::CfgW'(ang_reg[1][AngW-1] ? -r12 : r12);
        // tie goes to roll
        roll_dom = !(p_abs > r_abs);
        dir = tdd_pkg::MOVE_NONE;
        ind = tdd_pkg::IND_FLAT;
        if (!roll_dom)
        begin
            if (p12 < -trig12)
            begin
                dir = tdd_pkg::MOVE_UP;
                ind = tdd_pkg::IND_UP;
            end
            else if (p12 > trig12)
            begin
                dir = tdd_pkg::MOVE_DOWN;
                ind = tdd_pkg::IND_DOWN;
            end
            else if (p12 < -trend12)
                ind = tdd_pkg::IND_UP_TREND;
            else if (p12 > trend12)
                ind = tdd_pkg::IND_DOWN_TREND;
        end
        else
        begin
            if (r12 > trig12)
            begin
                dir = tdd_pkg::MOVE_RIGHT;
                ind = tdd_pkg::IND_RIGHT;
            end
            else if (r12 < -trig12)
            begin
                dir = tdd_pkg::MOVE_LEFT;
                ind = tdd_pkg::IND_LEFT;
            end
            else if (r12 > trend12)
                ind = tdd_pkg::IND_RIGHT_TREND;
            else if (r12 < -trend12)
                ind = tdd_pkg::IND_LEFT_TREND;
        end

        // rearm and fire may happen on the same sample
        rearm         = (p_abs < rel_reg) && (r_abs < rel_reg);
        blocked       = awaiting_reg && !rearm;
        awaiting_next = awaiting_reg && !rearm;
        move_val      = tdd_pkg::MOVE_NONE;
        if (!blocked && (dir != tdd_pkg::MOVE_NONE))
        begin
            awaiting_next = 1'b1;
            move_val      = dir;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            tdd_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = tdd_pkg::ST_SQR;
            end
            tdd_pkg::ST_SQR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                    state_next = tdd_pkg::ST_SUM;
            end
            tdd_pkg::ST_SUM:
                state_next = tdd_pkg::ST_ROOT;
            tdd_pkg::ST_ROOT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                    state_next = tdd_pkg::ST_ROT;
            end
            tdd_pkg::ST_ROT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                    state_next = tdd_pkg::ST_ANG;
            end
            tdd_pkg::ST_ANG:
                state_next = tdd_pkg::ST_DONE;
            tdd_pkg::ST_DONE:
            begin
                if (commit)
                    state_next = tdd_pkg::ST_IDLE;
            end
            default:
                state_next = tdd_pkg::ST_IDLE;
        endcase

        if (commit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            awaiting_reg  <= 1'b0;
            trig_reg      <= tdd_pkg::TriggerReset;
            rel_reg       <= tdd_pkg::ReleaseReset;
            trend_reg     <= tdd_pkg::TrendReset;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (commit)
                awaiting_reg <= awaiting_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    tdd_pkg::CFG_TRIGGER: trig_reg  <= cfg_wdata;
                    tdd_pkg::CFG_RELEASE: rel_reg   <= cfg_wdata;
                    tdd_pkg::CFG_TREND:   trend_reg <= cfg_wdata;
                    default:              ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tdd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    num_reg[0]    <= sample.accel_x;
                    num_reg[1]    <= sample.accel_y;
                    mplier_reg[0] <= mag16(sample.accel_x);
                    mplier_reg[1] <= mag16(sample.accel_y);
                    mplier_reg[2] <= mag16(sample.accel_z);
                    mcand_reg[0]  <= SqW'(mag16(sample.accel_x));
                    mcand_reg[1]  <= SqW'(mag16(sample.accel_y));
                    mcand_reg[2]  <= SqW'(mag16(sample.accel_z));
                    for (int l = 0; l < 3; l++)
                        sq_reg[l] <= '0;
                end
            end
            tdd_pkg::ST_SQR:
            begin
                // shift-add square, one multiplier bit per cycle
                for (int l = 0; l < 3; l++)
                begin
                    if (mplier_reg[l][0])
                        sq_reg[l] <= sq_reg[l] + mcand_reg[l];
                    mcand_reg[l]  <= {mcand_reg[l][SqW-2:0], 1'b0};
                    mplier_reg[l] <= {1'b0, mplier_reg[l][tdd_pkg::AccelW-1:1]};
                end
            end
            tdd_pkg::ST_SUM:
            begin
                rad_reg[0] <= RadW'(sq_reg[1]) + RadW'(sq_reg[2]);
                rad_reg[1] <= RadW'(sq_reg[0]) + RadW'(sq_reg[2]);
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[l]  <= '0;
                    root_reg[l] <= '0;
                end
            end
            tdd_pkg::ST_ROOT:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[l]  <= rem_nx[l];
                    root_reg[l] <= root_nx[l];
                    rad_reg[l]  <= {rad_reg[l][RadW-3:0], 2'b00};
                    if (last_step)
                    begin
                        cx_reg[l]   <= $signed({3'b000, root_nx[l], 8'h00});
                        cy_reg[l]   <= tdd_pkg::VecW'($signed({num_reg[l], 8'h00}));
                        cz_reg[l]   <= '0;
                        zero_reg[l] <= (root_nx[l] == '0) && (num_reg[l] == '0);
                    end
                end
            end
            tdd_pkg::ST_ROT:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    if (!cy_reg[l][tdd_pkg::VecW-1])
                    begin
                        cx_reg[l] <= cx_reg[l] + ys[l];
                        cy_reg[l] <= cy_reg[l] - xs[l];
                        cz_reg[l] <= cz_reg[l] + atan_s;
                    end
                    else
                    begin
                        cx_reg[l] <= cx_reg[l] - ys[l];
                        cy_reg[l] <= cy_reg[l] + xs[l];
                        cz_reg[l] <= cz_reg[l] - atan_s;
                    end
                end
            end
            tdd_pkg::ST_ANG:
            begin
                for (int l = 0; l < 2; l++)
                    ang_reg[l] <= ang_sat[l];
            end
            tdd_pkg::ST_DONE:
            begin
                if (commit)
                begin
                    move_reg      <= move_val;
                    ind_reg       <= ind;
                    pitch_out_reg <= ang_reg[0];
                    roll_out_reg  <= ang_reg[1];
                    rdom_reg      <= roll_dom;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.valid         = out_valid_reg;
    assign result.move          = move_reg;
    assign result.indicator     = ind_reg;
    assign result.pitch_tenths  = pitch_out_reg;
    assign result.roll_tenths   = roll_out_reg;
    assign result.roll_dominant = rdom_reg;

endmodule

// ===== tb/tilt_direction_detector_unit_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tilt_direction_detector_unit_test : self-checking bench for the tilt unit
// Sends acceleration sample requests through bursty valid/ready traffic and
// compares every result request against an in-bench pitch/roll predictor.
// Covers the three threshold registers across several settings, extremes
// included.
// ============================================================================
module tilt_direction_detector_unit_test;
    import tdd_pkg::*;

    // Index 3 is not decoded by the block; writes there must be dropped.
    localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 2'd3;
    // Gravity-sized z used to place a tilt on an exact angle.
    localparam int GravityRef = 16384;
    // Quiet period at the end, longer than the block latency.
    localparam int SettleCycles = 60;

    typedef struct {
        logic signed [AccelW-1:0] ax;
        logic signed [AccelW-1:0] ay;
        logic signed [AccelW-1:0] az;
    } sample_t;

    typedef struct {
        move_t                    move;
        ind_t                     indicator;
        logic signed [AngleW-1:0] pitch;
        logic signed [AngleW-1:0] roll;
        logic                     roll_dom;
    } tilt_result_t;

    // ------------------------------------------------------------------------
    // Bench-side signals, known from time zero
    // ------------------------------------------------------------------------
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_wen   = 1'b0;
    logic [CfgIdxW-1:0]       cfg_index = '0;
    logic [CfgW-1:0]          cfg_wdata = '0;
    logic                     in_valid  = 1'b0;
    logic signed [AccelW-1:0] in_ax     = '0;
    logic signed [AccelW-1:0] in_ay     = '0;
    logic signed [AccelW-1:0] in_az     = '0;
    logic                     out_ready = 1'b0;

    tdd_in_if  sample_ch ();
    tdd_out_if result_ch ();

    assign sample_ch.valid   = in_valid;
    assign sample_ch.accel_x = in_ax;
    assign sample_ch.accel_y = in_ay;
    assign sample_ch.accel_z = in_az;
    assign result_ch.ready   = out_ready;

    tilt_direction_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: thresholds as last written, and the rearm latch
    // ------------------------------------------------------------------------
    logic [CfgW-1:0] trigger_lim    = TriggerReset;
    logic [CfgW-1:0] release_lim    = ReleaseReset;
    logic [CfgW-1:0] trend_lim      = TrendReset;
    logic            awaiting_rearm = 1'b0;

    // atan(2^-i) in 1/256 of a tenth of a degree
    longint atan_steps [CordicN] = '{
        115200, 68007, 35933, 18240, 9155, 4582, 2292, 1146,
        573, 286, 143, 72, 36, 18, 9, 4
    };

    sample_t      pending_q [$];    // sample requests waiting for the driver
    tilt_result_t tilt_exp_q [$];   // predicted results, oldest first

    int  issued_cnt   = 0;
    int  checked_cnt  = 0;
    int  fail_cnt     = 0;
    int  moves_seen   = 0;
    int  settings_cnt = 1;
    logic no_idle     = 1'b0;       // one phase runs with no gaps and no stalls

    // Floor integer square root; the root of a 32-bit sum fits 16 bits.
    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        int b;
        root = 0;
        for (b = 16; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return longint'(root);
    endfunction

    // atan2(num, sqrt(a^2 + b^2)) in tenths of a degree, 16-step CORDIC
    // vectoring; >>> on a signed longint is the floor shift the block uses.
    function automatic int tilt_angle(longint num, longint a, longint b);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint t;
        int i;
        x = floor_sqrt(a * a + b * b) * 256;
        y = num * 256;
        z = 0;
        // zero vector: no angle at all
        if (x == 0 && num == 0)
            return 0;
        for (i = 0; i < CordicN; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_steps[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_steps[i];
            end
        end
        t = (z + 128) >>> 8;
        if (t > AngleMax)
            t = AngleMax;
        if (t < -AngleMax)
            t = -AngleMax;
        return int'(t);
    endfunction

    // Works out one result and advances the rearm latch, in accept order.
    function automatic tilt_result_t predict_tilt(sample_t s);
        tilt_result_t r;
        int pitch;
        int roll;
        int ap;
        int ar;
        int trig;
        int rel;
        int trend;
        move_t dir;
        logic blocked;
        pitch = tilt_angle(s.ax, s.ay, s.az);
        roll  = tilt_angle(s.ay, s.ax, s.az);
        ap    = (pitch < 0) ? -pitch : pitch;
        ar    = (roll < 0) ? -roll : roll;
        trig  = trigger_lim;
        rel   = release_lim;
        trend = trend_lim;
        dir   = MOVE_NONE;
        r.indicator = IND_FLAT;
        r.pitch     = AngleW'(pitch);
        r.roll      = AngleW'(roll);
        // a tie in magnitude goes to roll
        r.roll_dom  = !(ap > ar);
        if (!r.roll_dom)
        begin
            // negative pitch is up, positive is down
            if (pitch < -trig)
            begin
                dir = MOVE_UP;
                r.indicator = IND_UP;
            end
            else if (pitch > trig)
            begin
                dir = MOVE_DOWN;
                r.indicator = IND_DOWN;
            end
            else if (pitch < -trend)
                r.indicator = IND_UP_TREND;
            else if (pitch > trend)
                r.indicator = IND_DOWN_TREND;
        end
        else
        begin
            if (roll > trig)
            begin
                dir = MOVE_RIGHT;
                r.indicator = IND_RIGHT;
            end
            else if (roll < -trig)
            begin
                dir = MOVE_LEFT;
                r.indicator = IND_LEFT;
            end
            else if (roll > trend)
                r.indicator = IND_RIGHT_TREND;
            else if (roll < -trend)
                r.indicator = IND_LEFT_TREND;
        end
        // rearm needs both angles strictly inside the band; the same sample
        // may then fire straight away
        blocked = 1'b0;
        if (awaiting_rearm)
        begin
            if (ap < rel && ar < rel)
                awaiting_rearm = 1'b0;
            else
                blocked = 1'b1;
        end
        r.move = MOVE_NONE;
        if (!blocked && dir != MOVE_NONE)
        begin
            awaiting_rearm = 1'b1;
            r.move = dir;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: bursts of sample requests with random gaps in between
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        sample_t nxt;
        sample_t taken;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // request accepted at this edge: predict with the values held
            if (in_valid && sample_ch.ready)
            begin
                taken.ax = in_ax;
                taken.ay = in_ay;
                taken.az = in_az;
                tilt_exp_q.push_back(predict_tilt(taken));
            end
            if (!in_valid || sample_ch.ready)
            begin
                if (gap_left > 0 && !no_idle)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    nxt = pending_q.pop_front();
                    in_ax    <= nxt.ax;
                    in_ay    <= nxt.ay;
                    in_az    <= nxt.az;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        // no gap, a short one, or one long enough to land on
                        // any step of the sample sequence
                        case ($urandom_range(0, 2))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(1, 5);
                            default: gap_left = $urandom_range(6, 70);
                        endcase
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready runs high and low for random stretches
    // ------------------------------------------------------------------------
    int hold_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic stall;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else if (no_idle)
            out_ready <= 1'b1;
        else if (hold_left == 0)
        begin
            stall = ($urandom_range(0, 2) == 0);
            hold_left = stall ? $urandom_range(1, 60) : $urandom_range(1, 120);
            out_ready <= !stall;
        end
        else
            hold_left--;
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted result request against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic signed [31:0] want_v,
                               logic signed [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        tilt_result_t want;
        if (rst_n && result_ch.valid && out_ready)
        begin
            if (tilt_exp_q.size() == 0)
            begin
                $error("result request with no sample outstanding");
                fail_cnt++;
            end
            else
            begin
                want = tilt_exp_q.pop_front();
                check_field("move", want.move, result_ch.move);
                check_field("indicator", want.indicator, result_ch.indicator);
                check_field("pitch_tenths", want.pitch, result_ch.pitch_tenths);
                check_field("roll_tenths", want.roll, result_ch.roll_tenths);
                check_field("roll_dominant", want.roll_dom, result_ch.roll_dominant);
                if (want.move != MOVE_NONE)
                    moves_seen++;
                checked_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_sample(int ax, int ay, int az);
        sample_t s;
        s.ax = AccelW'(ax);
        s.ay = AccelW'(ay);
        s.az = AccelW'(az);
        pending_q.push_back(s);
        issued_cnt++;
    endtask

    // Every sample gives exactly one result, so the block is idle once all
    // queued requests have come back.
    task automatic drain();
        while (checked_cnt != issued_cnt)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_TRIGGER: trigger_lim = data;
            CFG_RELEASE: release_lim = data;
            CFG_TREND:   trend_lim   = data;
            default:     ;  // undecoded index, nothing changes
        endcase
    endtask

    task automatic apply_setting(int trig, int rel, int trend);
        drain();
        write_reg(CFG_TRIGGER, CfgW'(trig));
        write_reg(CFG_RELEASE, CfgW'(rel));
        write_reg(CFG_TREND, CfgW'(trend));
        write_reg(CfgUnusedIdx, CfgW'($urandom_range(0, 1023)));
        @(posedge clk);
        cfg_wen <= 1'b0;
        settings_cnt++;
    endtask

    // Smallest x magnitude that puts pitch on the target with z at 1 g;
    // the same magnitude on y gives that roll.
    function automatic int mag_for_angle(int target);
        int m;
        for (m = 0; m < 32767; m++)
            if (tilt_angle(m, 0, GravityRef) >= target)
                return m;
        return 32767;
    endfunction

    function automatic int extreme_value();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    // Mostly gravity-led tilts and near-flat samples so the fire/rearm cycle
    // keeps turning; the rest is raw noise, extremes and tiny vectors.
    task automatic queue_random(int count);
        int n;
        int g;
        int spread;
        int ax;
        int ay;
        int az;
        for (n = 0; n < count; n++)
        begin
            g = $urandom_range(4000, 20000);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    spread = 1 << $urandom_range(6, 15);
                    ax = int'($urandom_range(0, 2 * spread)) - spread;
                    ay = int'($urandom_range(0, 2 * spread)) - spread;
                    az = $urandom_range(0, 1) ? g : -g;
                end
                4, 5:
                begin
                    spread = 1 << $urandom_range(0, 10);
                    ax = int'($urandom_range(0, 2 * spread)) - spread;
                    ay = int'($urandom_range(0, 2 * spread)) - spread;
                    az = $urandom_range(0, 1) ? g : -g;
                end
                6, 7:
                begin
                    ax = $urandom();
                    ay = $urandom();
                    az = $urandom();
                end
                8:
                begin
                    ax = extreme_value();
                    ay = extreme_value();
                    az = extreme_value();
                end
                default:
                begin
                    ax = int'($urandom_range(0, 16)) - 8;
                    ay = int'($urandom_range(0, 16)) - 8;
                    az = int'($urandom_range(0, 16)) - 8;
                end
            endcase
            queue_sample(ax, ay, az);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int m50;
        int m51;
        int m99;
        int m100;
        int m150;
        int m200;
        int m201;
        int k;
        m50  = mag_for_angle(50);
        m51  = mag_for_angle(51);
        m99  = mag_for_angle(99);
        m100 = mag_for_angle(100);
        m150 = mag_for_angle(150);
        m200 = mag_for_angle(200);
        m201 = mag_for_angle(201);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset thresholds (trigger 200, release 100, trend 50).
        queue_sample(0, 0, 0);                  // zero vector
        queue_sample(0, 0, GravityRef);         // flat
        queue_sample(m50, 0, GravityRef);       // on the trend edge: flat
        queue_sample(m51, 0, GravityRef);       // down trend
        queue_sample(-m51, 0, GravityRef);      // up trend
        queue_sample(0, m51, GravityRef);       // right trend
        queue_sample(0, -m51, GravityRef);      // left trend
        queue_sample(m200, 0, GravityRef);      // on the trigger edge: no move
        queue_sample(m201, 0, GravityRef);      // down fires
        queue_sample(-m201, 0, GravityRef);     // held, waiting for release
        queue_sample(m100, 0, GravityRef);      // on the release edge: still held
        queue_sample(m99, 0, GravityRef);       // rearms
        queue_sample(-m201, 0, GravityRef);     // up fires
        queue_sample(0, 0, -32768);             // rearms, z at its minimum
        queue_sample(0, -m201, GravityRef);     // left fires
        queue_sample(0, 0, 1);                  // rearms
        queue_sample(0, m201, GravityRef);      // right fires
        queue_sample(0, 0, GravityRef);         // rearms
        queue_sample(16384, 16384, 0);          // equal angles: roll wins
        queue_sample(32767, 0, 0);              // full-scale pitch
        queue_sample(-32768, 0, 0);
        queue_sample(0, 0, 0);
        queue_sample(0, 32767, 0);              // full-scale roll
        queue_sample(0, -32768, 0);
        queue_sample(-32768, -32768, -32768);
        queue_sample(32767, 32767, 32767);
        queue_sample(1, 0, 0);                  // radius zero, numerator not
        queue_sample(-1, -1, -1);

        // Release band wider than trigger: one sample both rearms and fires.
        apply_setting(100, 300, 20);
        queue_sample(m150, 0, GravityRef);
        queue_sample(-m150, 0, GravityRef);
        queue_random(70);

        // Zero thresholds: anything off-axis is past the trigger, and nothing ever rearms.
        apply_setting(0, 0, 0);
        queue_random(70);

        // Largest legal angle and the all-ones register value: never fire.
        apply_setting(900, 900, 900);
        queue_random(60);
        apply_setting(1023, 1023, 1023);
        queue_random(40);

        // Back to reset values with traffic running flat out.
        apply_setting(200, 100, 50);
        no_idle = 1'b1;
        queue_random(70);
        drain();
        no_idle = 1'b0;

        // Trend above trigger, narrow release.
        apply_setting(450, 50, 899);
        queue_random(70);

        for (k = 0; k < 4; k++)
        begin
            apply_setting($urandom_range(0, 400), $urandom_range(0, 500),
                          $urandom_range(0, 300));
            queue_random(65);
        end

        drain();
        repeat (SettleCycles) @(posedge clk);
        if (tilt_exp_q.size() != 0)
        begin
            $error("%0d predicted results never arrived", tilt_exp_q.size());
            fail_cnt++;
        end

        $display("Checked %0d tilt results over %0d threshold settings, %0d moves fired",
                 checked_cnt, settings_cnt, moves_seen);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (~670 requests with worst gaps
    // and stalls).
    initial
    begin
        #2000000;
        $display("Watchdog expired with %0d of %0d results checked",
                 checked_cnt, issued_cnt);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tdd_pkg.sv
rtl/tdd_in_if.sv
rtl/tdd_out_if.sv
rtl/tilt_direction_detector_unit.sv
tb/tilt_direction_detector_unit_test.sv
